>>> design/tcas_pkg.sv
// Shared types, codes and constants of the three-class admission scheduler.
package tcas_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_TAG_WIDTH   = 16;

    // Fixed field widths.
    localparam int CAP_W      = 7;
    localparam int FLAG_W     = 3;
    localparam int MODE_W     = 2;
    localparam int QUANTA_W   = 24;
    localparam int QUANTUM_W  = 8;
    localparam int DEFICIT_W  = 16;
    localparam int CLASS_W    = 2;
    localparam int STATUS_W   = 3;
    localparam int DEPTH_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Traffic classes.
    localparam logic [CLASS_W-1:0] CLS_URGENT    = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_BROADBAND = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_IOT       = 2'd2;

    // Commands carried in the input tuser.
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_SERVE  = 1'b1;

    // Bit positions in preempt_flags.
    localparam int FLAG_PUSHOUT     = 0;
    localparam int FLAG_ADM_PREEMPT = 1;
    localparam int FLAG_SVC_PREEMPT = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOTAL_CAP     = 3'd0,
        REG_CAP_URGENT    = 3'd1,
        REG_CAP_BROADBAND = 3'd2,
        REG_CAP_IOT       = 3'd3,
        REG_PREEMPT_FLAGS = 3'd4,
        REG_SCHED_MODE    = 3'd5,
        REG_QUANTA        = 3'd6
    } reg_index_e;

    // Scheduling modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_STRICT    = 2'd0,
        MODE_PREEMPT   = 2'd1,
        MODE_RR_BORROW = 2'd2,
        MODE_RR        = 2'd3
    } sched_mode_e;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ADMIT        = 3'd0,
        ST_PREEMPT_DROP = 3'd1,
        ST_CAP_DROP     = 3'd2,
        ST_FULL_DROP    = 3'd3,
        ST_SERVED       = 3'd4,
        ST_EMPTY        = 3'd5
    } status_e;

    // Top-level sequencer states.
    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_READ = 1'b1
    } fsm_state_e;

    // Configuration register set.
    typedef struct packed {
        logic [CAP_W-1:0]    total_capacity;
        logic [CAP_W-1:0]    cap_urgent;
        logic [CAP_W-1:0]    cap_broadband;
        logic [CAP_W-1:0]    cap_iot;
        logic [FLAG_W-1:0]   preempt_flags;
        sched_mode_e         sched_mode;
        logic [QUANTA_W-1:0] quanta;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        total_capacity: 7'd64,
        cap_urgent:     7'd0,
        cap_broadband:  7'd0,
        cap_iot:        7'd0,
        preempt_flags:  3'd0,
        sched_mode:     MODE_RR,
        quanta:         24'd65793
    };

    // Decision of one item, handed from the queue control to the top level.
    typedef struct packed {
        status_e            status;
        logic               pushed_out;
        logic [CLASS_W-1:0] pushed_class;
        logic [CLASS_W-1:0] served_class;
    } result_info_t;

endpackage

>>> design/three_class_admission_scheduler.sv
// Top level of the three-class admission scheduler: ports, configuration, sequencing, output register.
//
//   Group   Signals                          Beat contents (low bit first)
//   s       s_tvalid s_tready s_tdata s_tuser  tuser: cmd; tdata: traffic_class, job_tag
//   m       m_tvalid m_tready m_tdata m_tuser  tuser: status; tdata: pushed_out,
//                                              pushed_class, served_class, served_tag,
//                                              depth_urgent, depth_broadband, depth_iot
//   cfg     cfg_we cfg_index cfg_wdata          register write, no read-back
//
// Each input beat passes through the idle and read states: the accept in idle decides, updates the
// queue counters and issues the tag memory read; the read state loads the result into the output register.
// The registered read port of the tag memory is the reason for the read state.
// A new beat is taken while a finished result waits in the output register; a stalled
// output keeps the block in the read state and holds off further input.
// Reset is asynchronous and clears all queues; no clearing pass is needed.
module three_class_admission_scheduler #(
    parameter int QUEUE_DEPTH = tcas_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_WIDTH   = tcas_pkg::DEF_TAG_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: traffic_class, job_tag
    input  logic [((TAG_WIDTH+2+7)/8)*8-1:0]       s_tdata,
    // tuser: cmd
    input  logic                                   s_tuser,
    // Result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: pushed_out, pushed_class, served_class, served_tag,
    //        depth_urgent, depth_broadband, depth_iot
    output logic [((TAG_WIDTH+26+7)/8)*8-1:0]      m_tdata,
    // tuser: status
    output logic [tcas_pkg::STATUS_W-1:0]          m_tuser,
    // Configuration write port
    input  logic                                   cfg_we,
    input  logic [tcas_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tcas_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    localparam int S_DATA_W  = ((TAG_WIDTH + 2 + 7) / 8) * 8;
    localparam int M_DATA_W  = ((TAG_WIDTH + 26 + 7) / 8) * 8;
    localparam int RAM_DEPTH = 3 * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int CW        = tcas_pkg::CLASS_W;
    localparam int IN_TAG_LO = CW;
    localparam int PUSH_LO   = 0;
    localparam int SCLS_LO   = 1 + CW;
    localparam int TAG_LO    = 1 + 2 * CW;

    tcas_pkg::cfg_t         cfg_reg;
    tcas_pkg::fsm_state_e   state_reg;
    tcas_pkg::fsm_state_e   state_next;
    tcas_pkg::result_info_t info;
    tcas_pkg::result_info_t info_reg;

    logic                         fire;
    logic                         load_out;
    logic                         ram_wr_en;
    logic [ADDR_W-1:0]            ram_wr_addr;
    logic [ADDR_W-1:0]            ctrl_rd_addr;
    logic [ADDR_W-1:0]            rd_addr_reg;
    logic [ADDR_W-1:0]            ram_rd_addr;
    logic [TAG_WIDTH-1:0]         ram_rd_data;
    logic [TAG_WIDTH-1:0]         served_tag;
    logic [tcas_pkg::DEPTH_W-1:0] depth_urgent;
    logic [tcas_pkg::DEPTH_W-1:0] depth_broadband;
    logic [tcas_pkg::DEPTH_W-1:0] depth_iot;
    logic                         m_tvalid_reg;
    logic [M_DATA_W-1:0]          m_tdata_reg;
    logic [M_DATA_W-1:0]          m_tdata_next;
    logic [tcas_pkg::STATUS_W-1:0] m_tuser_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= tcas_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (tcas_pkg::reg_index_e'(cfg_index))
                tcas_pkg::REG_TOTAL_CAP:     cfg_reg.total_capacity <= cfg_wdata[6:0];
                tcas_pkg::REG_CAP_URGENT:    cfg_reg.cap_urgent     <= cfg_wdata[6:0];
                tcas_pkg::REG_CAP_BROADBAND: cfg_reg.cap_broadband  <= cfg_wdata[6:0];
                tcas_pkg::REG_CAP_IOT:       cfg_reg.cap_iot        <= cfg_wdata[6:0];
                tcas_pkg::REG_PREEMPT_FLAGS: cfg_reg.preempt_flags  <= cfg_wdata[2:0];
                tcas_pkg::REG_SCHED_MODE:
                    cfg_reg.sched_mode <= tcas_pkg::sched_mode_e'(cfg_wdata[1:0]);
                tcas_pkg::REG_QUANTA:        cfg_reg.quanta         <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: accept in idle, deliver from the read state.
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            tcas_pkg::FSM_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = tcas_pkg::FSM_READ;
                end
            end
            tcas_pkg::FSM_READ:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = tcas_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = tcas_pkg::FSM_IDLE;
            end
        endcase
    end

    assign fire = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcas_pkg::FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Queue control: decision and pointer updates.
    tcas_queue_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .item_fire       (fire),
        .cmd             (s_tuser),
        .traffic_class   (s_tdata[CW-1:0]),
        .info            (info),
        .wr_en           (ram_wr_en),
        .wr_addr         (ram_wr_addr),
        .rd_addr         (ctrl_rd_addr),
        .depth_urgent    (depth_urgent),
        .depth_broadband (depth_broadband),
        .depth_iot       (depth_iot)
    );

    // Hold the decision and read address of the item in flight.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            info_reg    <= info;
            rd_addr_reg <= ctrl_rd_addr;
        end
    end

    // The read address stays put while a stalled result waits.
    assign ram_rd_addr = (state_reg == tcas_pkg::FSM_IDLE) ? ctrl_rd_addr : rd_addr_reg;

    tcas_tag_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (TAG_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_tdata[IN_TAG_LO +: TAG_WIDTH]),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Result beat assembly.
    always_comb
    begin
        served_tag   = (info_reg.status == tcas_pkg::ST_SERVED) ? ram_rd_data : '0;
        m_tdata_next = M_DATA_W'({depth_iot, depth_broadband, depth_urgent, served_tag,
                                  info_reg.served_class, info_reg.pushed_class,
                                  info_reg.pushed_out});
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= info_reg.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    // Only one beat is in flight between accept and result load.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (state_reg == tcas_pkg::FSM_READ) && !s_tready)
        else $error("input accepted while a memory read was in flight");

    // A push-out happens only on an urgent arrival that passed the early checks.
    a_pushout_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[PUSH_LO]) |->
        (m_tuser == tcas_pkg::ST_ADMIT || m_tuser == tcas_pkg::ST_FULL_DROP))
        else $error("push-out reported with an unexpected status");

    // Served class and tag are zero on every result that is not a served job.
    a_quiet_serve_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != tcas_pkg::ST_SERVED) |->
        (m_tdata[SCLS_LO +: CW] == '0) && (m_tdata[TAG_LO +: TAG_WIDTH] == '0))
        else $error("served fields not cleared on a non-serve result");
`endif

endmodule

>>> design/tcas_tag_ram.sv
// Tag memory shared by the three queues: one write port, one registered read port.
module tcas_tag_ram #(
    parameter int DEPTH = 3 * tcas_pkg::DEF_QUEUE_DEPTH,
    parameter int WIDTH = tcas_pkg::DEF_TAG_WIDTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/tcas_queue_ctrl.sv
// Queue pointers, occupancies, deficit counters and the admission and service decision.
module tcas_queue_ctrl #(
    parameter int QUEUE_DEPTH = tcas_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tcas_pkg::cfg_t                       cfg,
    input  logic                                 item_fire,
    input  logic                                 cmd,
    input  logic [tcas_pkg::CLASS_W-1:0]         traffic_class,
    output tcas_pkg::result_info_t               info,
    output logic                                 wr_en,
    output logic [$clog2(3*QUEUE_DEPTH)-1:0]     wr_addr,
    output logic [$clog2(3*QUEUE_DEPTH)-1:0]     rd_addr,
    output logic [tcas_pkg::DEPTH_W-1:0]         depth_urgent,
    output logic [tcas_pkg::DEPTH_W-1:0]         depth_broadband,
    output logic [tcas_pkg::DEPTH_W-1:0]         depth_iot
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = $clog2(3 * QUEUE_DEPTH + 1);
    localparam int CMP_W  = (SUM_W > tcas_pkg::CAP_W) ? SUM_W : tcas_pkg::CAP_W;
    localparam int ADDR_W = $clog2(3 * QUEUE_DEPTH);
    localparam int OUTX_W = (CNT_W > tcas_pkg::DEPTH_W) ? CNT_W : tcas_pkg::DEPTH_W;
    localparam int DW     = tcas_pkg::DEFICIT_W;
    localparam int QW     = tcas_pkg::QUANTUM_W;

    logic [PTR_W-1:0]  head_reg    [3];
    logic [PTR_W-1:0]  head_next   [3];
    logic [CNT_W-1:0]  cnt_reg     [3];
    logic [CNT_W-1:0]  cnt_next    [3];
    logic [DW-1:0]     deficit_reg [3];
    logic [DW-1:0]     deficit_next[3];
    logic [1:0]        turn_reg;
    logic [1:0]        turn_next;

    logic [PTR_W-1:0]  head_inc    [3];
    logic [PTR_W-1:0]  push_slot   [3];
    logic [PTR_W:0]    slot_sum    [3];
    logic [2:0]        busy;

    logic [tcas_pkg::CLASS_W-1:0] tc_eff;
    logic [tcas_pkg::CLASS_W-1:0] pop_cls;
    logic [tcas_pkg::CAP_W-1:0]   cap_sel;
    logic [CNT_W-1:0]             cnt_sel;
    logic [SUM_W-1:0]             total;
    logic [SUM_W-1:0]             total_after;
    logic                         push_en;
    logic                         pop_en;
    logic                         rr_update;
    logic [OUTX_W-1:0]            ext_u;
    logic [OUTX_W-1:0]            ext_b;
    logic [OUTX_W-1:0]            ext_i;

    // Base address of a class region in the shared tag memory.
    function automatic logic [ADDR_W-1:0] class_base(input logic [tcas_pkg::CLASS_W-1:0] c);
        logic [ADDR_W-1:0] base;
        case (c)
            tcas_pkg::CLS_URGENT:    base = '0;
            tcas_pkg::CLS_BROADBAND: base = ADDR_W'(QUEUE_DEPTH);
            default:                 base = ADDR_W'(2 * QUEUE_DEPTH);
        endcase
        return base;
    endfunction

    // First non-empty class in round-robin order starting at the current turn.
    function automatic logic [1:0] rr_pick(input logic [1:0] start, input logic [2:0] nonempty);
        logic [1:0] a;
        logic [1:0] b;
        logic [1:0] c;
        logic [1:0] pick;
        case (start)
            tcas_pkg::CLS_BROADBAND:
            begin
                a = tcas_pkg::CLS_BROADBAND;
                b = tcas_pkg::CLS_IOT;
                c = tcas_pkg::CLS_URGENT;
            end
            tcas_pkg::CLS_IOT:
            begin
                a = tcas_pkg::CLS_IOT;
                b = tcas_pkg::CLS_URGENT;
                c = tcas_pkg::CLS_BROADBAND;
            end
            default:
            begin
                a = tcas_pkg::CLS_URGENT;
                b = tcas_pkg::CLS_BROADBAND;
                c = tcas_pkg::CLS_IOT;
            end
        endcase
        if (nonempty[a])
        begin
            pick = a;
        end
        else if (nonempty[b])
        begin
            pick = b;
        end
        else
        begin
            pick = c;
        end
        return pick;
    endfunction

    // Per-class pointer arithmetic: next head and tail slot, both wrapped.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            head_inc[c] = (head_reg[c] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg[c] + 1'b1;
            slot_sum[c] = (PTR_W + 1)'(head_reg[c]) + (PTR_W + 1)'(cnt_reg[c]);
            if (slot_sum[c] >= (PTR_W + 1)'(QUEUE_DEPTH))
            begin
                push_slot[c] = PTR_W'(slot_sum[c] - (PTR_W + 1)'(QUEUE_DEPTH));
            end
            else
            begin
                push_slot[c] = PTR_W'(slot_sum[c]);
            end
            busy[c] = (cnt_reg[c] != '0);
        end
    end

    // Admission and service decision for the item at the input.
    always_comb
    begin
        tc_eff = (traffic_class > tcas_pkg::CLS_IOT) ? tcas_pkg::CLS_IOT : traffic_class;
        case (tc_eff)
            tcas_pkg::CLS_URGENT:
            begin
                cap_sel = cfg.cap_urgent;
                cnt_sel = cnt_reg[0];
            end
            tcas_pkg::CLS_BROADBAND:
            begin
                cap_sel = cfg.cap_broadband;
                cnt_sel = cnt_reg[1];
            end
            default:
            begin
                cap_sel = cfg.cap_iot;
                cnt_sel = cnt_reg[2];
            end
        endcase
        total = SUM_W'(cnt_reg[0]) + SUM_W'(cnt_reg[1]) + SUM_W'(cnt_reg[2]);
        total_after = total;

        info.status       = tcas_pkg::ST_ADMIT;
        info.pushed_out   = 1'b0;
        info.pushed_class = tcas_pkg::CLS_URGENT;
        info.served_class = tcas_pkg::CLS_URGENT;
        push_en   = 1'b0;
        pop_en    = 1'b0;
        pop_cls   = tcas_pkg::CLS_URGENT;
        rr_update = 1'b0;

        if (cmd == tcas_pkg::CMD_ARRIVE)
        begin
            if (cfg.preempt_flags[tcas_pkg::FLAG_ADM_PREEMPT] && tc_eff != tcas_pkg::CLS_URGENT
                && busy[0])
            begin
                info.status = tcas_pkg::ST_PREEMPT_DROP;
            end
            else if (cap_sel != '0 && CMP_W'(cnt_sel) >= CMP_W'(cap_sel))
            begin
                info.status = tcas_pkg::ST_CAP_DROP;
            end
            else if (cnt_sel >= CNT_W'(QUEUE_DEPTH))
            begin
                info.status = tcas_pkg::ST_FULL_DROP;
            end
            else
            begin
                // Push out the oldest broadband job, else the oldest IoT job.
                if (CMP_W'(total) >= CMP_W'(cfg.total_capacity) && tc_eff == tcas_pkg::CLS_URGENT
                    && cfg.preempt_flags[tcas_pkg::FLAG_PUSHOUT])
                begin
                    if (busy[1])
                    begin
                        pop_en            = 1'b1;
                        pop_cls           = tcas_pkg::CLS_BROADBAND;
                        info.pushed_out   = 1'b1;
                        info.pushed_class = tcas_pkg::CLS_BROADBAND;
                        total_after       = total - 1'b1;
                    end
                    else if (busy[2])
                    begin
                        pop_en            = 1'b1;
                        pop_cls           = tcas_pkg::CLS_IOT;
                        info.pushed_out   = 1'b1;
                        info.pushed_class = tcas_pkg::CLS_IOT;
                        total_after       = total - 1'b1;
                    end
                end
                if (CMP_W'(total_after) >= CMP_W'(cfg.total_capacity))
                begin
                    info.status = tcas_pkg::ST_FULL_DROP;
                end
                else
                begin
                    push_en     = 1'b1;
                    info.status = tcas_pkg::ST_ADMIT;
                end
            end
        end
        else
        begin
            if (busy == 3'b000)
            begin
                info.status = tcas_pkg::ST_EMPTY;
            end
            else
            begin
                info.status = tcas_pkg::ST_SERVED;
                pop_en      = 1'b1;
                if (cfg.sched_mode == tcas_pkg::MODE_PREEMPT
                    && cfg.preempt_flags[tcas_pkg::FLAG_SVC_PREEMPT] && busy[0])
                begin
                    pop_cls = tcas_pkg::CLS_URGENT;
                end
                else if (cfg.sched_mode == tcas_pkg::MODE_STRICT)
                begin
                    pop_cls = busy[0] ? tcas_pkg::CLS_URGENT :
                              busy[1] ? tcas_pkg::CLS_BROADBAND : tcas_pkg::CLS_IOT;
                end
                else
                begin
                    // Every deficit is at least one after the quantum add, so the
                    // first non-empty queue in turn order always takes the turn.
                    rr_update = 1'b1;
                    pop_cls   = rr_pick(turn_reg, busy);
                end
                info.served_class = pop_cls;
            end
        end
    end

    // Next pointers, occupancies, deficits and turn.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [DW:0]   dsum;
            logic [QW-1:0] q;
            head_next[c]    = head_reg[c];
            cnt_next[c]     = cnt_reg[c];
            deficit_next[c] = deficit_reg[c];
            if (item_fire && pop_en && pop_cls == 2'(c))
            begin
                head_next[c] = head_inc[c];
                cnt_next[c]  = cnt_reg[c] - 1'b1;
            end
            if (item_fire && push_en && tc_eff == 2'(c))
            begin
                cnt_next[c] = cnt_reg[c] + 1'b1;
            end
            q = cfg.quanta[QW*c +: QW];
            if (q == '0)
            begin
                q = QW'(1);
            end
            dsum = (DW + 1)'(deficit_reg[c]) + (DW + 1)'(q);
            if (item_fire && rr_update)
            begin
                deficit_next[c] = dsum[DW] ? {DW{1'b1}} : dsum[DW-1:0];
                if (pop_cls == 2'(c))
                begin
                    deficit_next[c] = deficit_next[c] - 1'b1;
                end
            end
        end
        turn_next = turn_reg;
        if (item_fire && rr_update)
        begin
            turn_next = (pop_cls == tcas_pkg::CLS_IOT) ? tcas_pkg::CLS_URGENT : pop_cls + 1'b1;
        end
    end

    // Queue state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                head_reg[c]    <= '0;
                cnt_reg[c]     <= '0;
                deficit_reg[c] <= '0;
            end
            turn_reg <= '0;
        end
        else
        begin
            for (int c = 0; c < 3; c++)
            begin
                head_reg[c]    <= head_next[c];
                cnt_reg[c]     <= cnt_next[c];
                deficit_reg[c] <= deficit_next[c];
            end
            turn_reg <= turn_next;
        end
    end

    // Memory addresses: tail slot of the arriving class, head of the popped class.
    always_comb
    begin
        case (tc_eff)
            tcas_pkg::CLS_URGENT:    wr_addr = class_base(tc_eff) + ADDR_W'(push_slot[0]);
            tcas_pkg::CLS_BROADBAND: wr_addr = class_base(tc_eff) + ADDR_W'(push_slot[1]);
            default:                 wr_addr = class_base(tc_eff) + ADDR_W'(push_slot[2]);
        endcase
        case (pop_cls)
            tcas_pkg::CLS_URGENT:    rd_addr = class_base(pop_cls) + ADDR_W'(head_reg[0]);
            tcas_pkg::CLS_BROADBAND: rd_addr = class_base(pop_cls) + ADDR_W'(head_reg[1]);
            default:                 rd_addr = class_base(pop_cls) + ADDR_W'(head_reg[2]);
        endcase
        wr_en = item_fire && push_en;
    end

    // Occupancies reported with the result, low seven bits.
    assign ext_u           = OUTX_W'(cnt_reg[0]);
    assign ext_b           = OUTX_W'(cnt_reg[1]);
    assign ext_i           = OUTX_W'(cnt_reg[2]);
    assign depth_urgent    = ext_u[tcas_pkg::DEPTH_W-1:0];
    assign depth_broadband = ext_b[tcas_pkg::DEPTH_W-1:0];
    assign depth_iot       = ext_i[tcas_pkg::DEPTH_W-1:0];

endmodule

>>> verif/tb_three_class_admission_scheduler.sv
// Self-checking testbench for the three-class admission scheduler: stream stimulus and scoreboard.
`timescale 1ns / 1ps

module tb_three_class_admission_scheduler;
    import tcas_pkg::*;

    localparam int QDEPTH      = DEF_QUEUE_DEPTH;
    localparam int TAG_W       = DEF_TAG_WIDTH;
    localparam int TURN_TRIES  = 9;
    localparam int DEFICIT_MAX = 65535;
    localparam int SDATA_W     = ((TAG_W + 2 + 7) / 8) * 8;
    localparam int MDATA_W     = ((TAG_W + 26 + 7) / 8) * 8;
    localparam int REPORT_MAX  = 40;

    // An arriving class of three is folded into IoT by the block.
    localparam logic [CLASS_W-1:0] CLS_SPARE = 2'd3;

    // Outcome of one request as the block should report it.
    typedef struct {
        status_e             status;
        logic                pushed_out;
        logic [CLASS_W-1:0]  pushed_class;
        logic [CLASS_W-1:0]  served_class;
        logic [TAG_W-1:0]    served_tag;
        logic [DEPTH_W-1:0]  depth_urgent;
        logic [DEPTH_W-1:0]  depth_broadband;
        logic [DEPTH_W-1:0]  depth_iot;
    } outcome_t;

    // One traffic phase: register settings plus the shape of its random requests.
    typedef struct {
        int unsigned   total;
        int unsigned   cap_u;
        int unsigned   cap_b;
        int unsigned   cap_i;
        int unsigned   flags;
        sched_mode_e   mode;
        int unsigned   quanta;
        int unsigned   items;
        int unsigned   arrive_pct;
        int unsigned   urgent_pct;
    } traffic_phase_t;

    // Scoreboard: keeps its own copy of the queues, deficits and registers.
    class admission_scoreboard;
        logic [TAG_W-1:0]     tag_store [3][QDEPTH];
        int unsigned          head [3];
        int unsigned          count [3];
        int unsigned          deficit [3];
        int unsigned          turn;
        int unsigned          total_capacity;
        int unsigned          class_cap [3];
        logic [FLAG_W-1:0]    flags;
        sched_mode_e          mode;
        logic [QUANTA_W-1:0]  quanta;
        outcome_t             expected_outcomes [$];
        int                   failures;

        function new();
            for (int c = 0; c < 3; c++)
            begin
                head[c]    = 0;
                count[c]   = 0;
                deficit[c] = 0;
            end
            turn           = 0;
            total_capacity = CFG_RESET.total_capacity;
            class_cap[0]   = CFG_RESET.cap_urgent;
            class_cap[1]   = CFG_RESET.cap_broadband;
            class_cap[2]   = CFG_RESET.cap_iot;
            flags          = CFG_RESET.preempt_flags;
            mode           = CFG_RESET.sched_mode;
            quanta         = CFG_RESET.quanta;
            failures       = 0;
        endfunction

        function void write_register(reg_index_e idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_TOTAL_CAP:     total_capacity = value[CAP_W-1:0];
                REG_CAP_URGENT:    class_cap[0] = value[CAP_W-1:0];
                REG_CAP_BROADBAND: class_cap[1] = value[CAP_W-1:0];
                REG_CAP_IOT:       class_cap[2] = value[CAP_W-1:0];
                REG_PREEMPT_FLAGS: flags = value[FLAG_W-1:0];
                REG_SCHED_MODE:    mode = sched_mode_e'(value[MODE_W-1:0]);
                REG_QUANTA:        quanta = value[QUANTA_W-1:0];
                default:           ;
            endcase
        endfunction

        function void enqueue_job(int unsigned c, logic [TAG_W-1:0] tag);
            tag_store[c][(head[c] + count[c]) % QDEPTH] = tag;
            count[c]++;
        endfunction

        function logic [TAG_W-1:0] dequeue_job(int unsigned c);
            logic [TAG_W-1:0] tag;
            tag     = tag_store[c][head[c]];
            head[c] = (head[c] + 1) % QDEPTH;
            count[c]--;
            return tag;
        endfunction

        function int unsigned strict_choice();
            if (count[CLS_URGENT] != 0)
                return CLS_URGENT;
            if (count[CLS_BROADBAND] != 0)
                return CLS_BROADBAND;
            return CLS_IOT;
        endfunction

        // Class picked by a serve: urgent preemption, strict order or deficit round robin.
        function int unsigned choose_class();
            int unsigned q;
            int unsigned idx;
            if (mode == MODE_PREEMPT && flags[FLAG_SVC_PREEMPT] && count[CLS_URGENT] != 0)
                return CLS_URGENT;
            if (mode == MODE_STRICT)
                return strict_choice();
            // Every serve that reaches round robin refills all deficits, saturating.
            for (int c = 0; c < 3; c++)
            begin
                q = quanta[8*c +: QUANTUM_W];
                if (q == 0)
                    q = 1;
                deficit[c] += q;
                if (deficit[c] > DEFICIT_MAX)
                    deficit[c] = DEFICIT_MAX;
            end
            for (int t = 0; t < TURN_TRIES; t++)
            begin
                idx  = turn;
                turn = (turn >= 2) ? 0 : turn + 1;
                if (count[idx] != 0 && deficit[idx] > 0)
                begin
                    deficit[idx]--;
                    return idx;
                end
                if (mode == MODE_RR_BORROW && count[idx] != 0)
                    return idx;
            end
            return strict_choice();
        endfunction

        // Works out the outcome of an accepted request and queues it.
        function void note_request(logic cmd, logic [CLASS_W-1:0] cls, logic [TAG_W-1:0] tag);
            outcome_t    o;
            int unsigned tc;
            int unsigned total;
            o.status       = ST_ADMIT;
            o.pushed_out   = 1'b0;
            o.pushed_class = '0;
            o.served_class = '0;
            o.served_tag   = '0;
            tc    = (cls == CLS_SPARE) ? CLS_IOT : cls;
            total = count[0] + count[1] + count[2];
            if (cmd == CMD_ARRIVE)
            begin
                if (flags[FLAG_ADM_PREEMPT] && tc != CLS_URGENT && count[CLS_URGENT] != 0)
                    o.status = ST_PREEMPT_DROP;
                else if (class_cap[tc] > 0 && count[tc] >= class_cap[tc])
                    o.status = ST_CAP_DROP;
                else if (count[tc] >= QDEPTH)
                    o.status = ST_FULL_DROP;
                else
                begin
                    // At most one older job makes room for an urgent arrival.
                    if (total >= total_capacity && tc == CLS_URGENT && flags[FLAG_PUSHOUT])
                    begin
                        if (count[CLS_BROADBAND] != 0)
                        begin
                            void'(dequeue_job(CLS_BROADBAND));
                            o.pushed_out   = 1'b1;
                            o.pushed_class = CLS_BROADBAND;
                        end
                        else if (count[CLS_IOT] != 0)
                        begin
                            void'(dequeue_job(CLS_IOT));
                            o.pushed_out   = 1'b1;
                            o.pushed_class = CLS_IOT;
                        end
                        total = count[0] + count[1] + count[2];
                    end
                    if (total >= total_capacity)
                        o.status = ST_FULL_DROP;
                    else
                        enqueue_job(tc, tag);
                end
            end
            else if (total == 0)
                o.status = ST_EMPTY;
            else
            begin
                o.served_class = CLASS_W'(choose_class());
                o.served_tag   = dequeue_job(o.served_class);
                o.status       = ST_SERVED;
            end
            o.depth_urgent    = DEPTH_W'(count[CLS_URGENT]);
            o.depth_broadband = DEPTH_W'(count[CLS_BROADBAND]);
            o.depth_iot       = DEPTH_W'(count[CLS_IOT]);
            expected_outcomes.insert(expected_outcomes.size(), o);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                if (failures < REPORT_MAX)
                    $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        // Compares one result beat with the oldest outstanding outcome.
        function void check_result(logic [STATUS_W-1:0] st, logic [MDATA_W-1:0] d);
            outcome_t o;
            if (expected_outcomes.size() == 0)
            begin
                if (failures < REPORT_MAX)
                    $error("result beat with no request outstanding");
                failures++;
                return;
            end
            o = expected_outcomes[0];
            expected_outcomes.delete(0);
            compare_field("status", o.status, st);
            compare_field("pushed_out", o.pushed_out, d[0]);
            compare_field("pushed_class", o.pushed_class, d[2:1]);
            compare_field("served_class", o.served_class, d[4:3]);
            compare_field("served_tag", o.served_tag, d[20:5]);
            compare_field("depth_urgent", o.depth_urgent, d[27:21]);
            compare_field("depth_broadband", o.depth_broadband, d[34:28]);
            compare_field("depth_iot", o.depth_iot, d[41:35]);
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SDATA_W-1:0]     s_tdata = '0;
    logic                   s_tuser = CMD_ARRIVE;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [MDATA_W-1:0]     m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_TOTAL_CAP;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    admission_scoreboard sb = new();
    int burst_left = 0;
    int stall_left = 0;
    int stall_kind = 0;
    int rx_cycle   = 0;

    three_class_admission_scheduler #(
        .QUEUE_DEPTH (QDEPTH),
        .TAG_WIDTH   (TAG_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("three_class_admission_scheduler: mismatch");
        $finish;
    end

    // Result side backpressure: runs of always ready, random stalls and sparse ready.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (stall_left == 0)
        begin
            stall_kind <= $urandom_range(2);
            stall_left <= $urandom_range(50, 300);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_kind)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(9) < 7);
            default: m_tready <= (rx_cycle % 4 == 0);
        endcase
    end

    // Beat monitor: results are checked before the request of the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[CLASS_W-1:0], s_tdata[CLASS_W +: TAG_W]);
        end
    end

    // Presents one request beat and returns at the edge that accepts it.
    task automatic send_request(input logic cmd, input logic [CLASS_W-1:0] cls,
                                input logic [TAG_W-1:0] tag);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(SDATA_W - TAG_W - CLASS_W){1'b0}}, tag, cls};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Holds off until every outstanding result has been checked.
    // The first edge lets the monitor note the last accepted beat.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_e idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge clk);
        sb.write_register(idx, CFG_DATA_W'(value));
    endtask

    task automatic apply_settings(input traffic_phase_t p);
        write_reg(REG_TOTAL_CAP, p.total);
        write_reg(REG_CAP_URGENT, p.cap_u);
        write_reg(REG_CAP_BROADBAND, p.cap_b);
        write_reg(REG_CAP_IOT, p.cap_i);
        write_reg(REG_PREEMPT_FLAGS, p.flags);
        write_reg(REG_SCHED_MODE, p.mode);
        write_reg(REG_QUANTA, p.quanta);
        cfg_we <= 1'b0;
    endtask

    // Random requests shaped by the phase's arrival and urgent shares.
    task automatic run_traffic(input traffic_phase_t p);
        logic                cmd;
        logic [CLASS_W-1:0]  cls;
        logic [TAG_W-1:0]    tag;
        int                  r;
        for (int n = 0; n < p.items; n++)
        begin
            cmd = ($urandom_range(99) < p.arrive_pct) ? CMD_ARRIVE : CMD_SERVE;
            r   = $urandom_range(99);
            if (r < p.urgent_pct)
                cls = CLS_URGENT;
            else if (r < p.urgent_pct + (100 - p.urgent_pct) / 2)
                cls = CLS_BROADBAND;
            else
                cls = ($urandom_range(3) == 0) ? CLS_SPARE : CLS_IOT;
            r   = $urandom_range(15);
            tag = (r == 0) ? '0 : (r == 1) ? '1 : TAG_W'($urandom_range(0, 65535));
            send_request(cmd, cls, tag);
        end
        drain_results();
    endtask

    traffic_phase_t pushout_setup = '{2, 0, 1, 0, 7, MODE_PREEMPT, 0, 0, 0, 0};
    traffic_phase_t plan [8] = '{
        '{64,  0,  0,  0, 1, MODE_STRICT,    24'h000000, 200, 80, 85},
        '{64,  0,  0,  0, 7, MODE_PREEMPT,   24'hFFFFFF, 150, 30, 30},
        '{10,  5,  8, 64, 1, MODE_RR_BORROW, 24'h030201, 250, 60, 35},
        '{ 0,  1,  1,  1, 3, MODE_PREEMPT,   24'h000000,  60, 50, 50},
        '{64,  0,  0,  0, 0, MODE_RR,        24'hFFFFFF, 400, 55, 33},
        '{32, 64, 64,  1, 5, MODE_RR_BORROW, 24'h000000, 250, 55, 30},
        '{20,  1,  0,  3, 6, MODE_STRICT,    24'h80FF7F, 150, 50, 40},
        '{64,  0,  0,  0, 4, MODE_RR,        24'h010203, 190, 65, 40}
    };

    // Main sequence: reset, directed cases, then the random phases.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty serve, one job per class including class three, round robin drain.
        send_request(CMD_SERVE, CLS_URGENT, '0);
        send_request(CMD_ARRIVE, CLS_URGENT, 16'h0000);
        send_request(CMD_ARRIVE, CLS_BROADBAND, 16'hFFFF);
        send_request(CMD_ARRIVE, CLS_IOT, 16'hA5A5);
        send_request(CMD_ARRIVE, CLS_SPARE, 16'h5A5A);
        repeat (5) send_request(CMD_SERVE, CLS_SPARE, 16'hFFFF);
        drain_results();

        // Tiny buffer: cap drop, push-out of broadband then IoT, full drop,
        // admission preemption and urgent-first service.
        apply_settings(pushout_setup);
        send_request(CMD_ARRIVE, CLS_BROADBAND, 16'h1111);
        send_request(CMD_ARRIVE, CLS_BROADBAND, 16'h2222);
        send_request(CMD_ARRIVE, CLS_IOT, 16'h3333);
        send_request(CMD_ARRIVE, CLS_URGENT, 16'h4444);
        send_request(CMD_ARRIVE, CLS_URGENT, 16'h5555);
        send_request(CMD_ARRIVE, CLS_URGENT, 16'h6666);
        send_request(CMD_ARRIVE, CLS_BROADBAND, 16'h7777);
        repeat (3) send_request(CMD_SERVE, CLS_URGENT, '0);
        drain_results();

        foreach (plan[i])
        begin
            apply_settings(plan[i]);
            run_traffic(plan[i]);
        end

        repeat (8) @(posedge clk);
        if (sb.failures == 0)
            $display("three_class_admission_scheduler: match");
        else
            $display("three_class_admission_scheduler: mismatch");
        $finish;
    end

endmodule

>>> files.f
design/tcas_pkg.sv
design/tcas_tag_ram.sv
design/tcas_queue_ctrl.sv
design/three_class_admission_scheduler.sv
verif/tb_three_class_admission_scheduler.sv
